@@ hdl/tlrb_pkg.sv @@
// tlrb_pkg: shared types and constants of the terminated line ring buffer
// no dependencies; compiled before every other file of the block
package tlrb_pkg;

  localparam int BYTE_W = 8;
  localparam int CHAR_W = 7;
  localparam int LEN_W  = 7;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_END_SYMBOL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRINT  = 1'b1;

  localparam logic [BYTE_W-1:0] END_SYMBOL_RST = 8'd13;
  localparam logic [CHAR_W-1:0] MIN_PRINT_RST  = 7'd32;

  // result status codes
  localparam logic STAT_CHAR    = 1'b0;
  localparam logic STAT_NO_LINE = 1'b1;

  // shared ring position unit operations
  typedef enum logic {
    ALU_INC,
    ALU_DIST
  } alu_op_t;

  // line end queue controls
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

endpackage

@@ hdl/tlrb_in_if.sv @@
// tlrb_in_if: input item channel (command, received byte, length limit)
// depends on tlrb_pkg for field widths
interface tlrb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [tlrb_pkg::BYTE_W-1:0] rx_byte;
  logic [tlrb_pkg::LEN_W-1:0]  max_len;

  modport source(output valid, output command, output rx_byte, output max_len, input ready);
  modport sink(input valid, input command, input rx_byte, input max_len, output ready);
endinterface

@@ hdl/tlrb_out_if.sv @@
// tlrb_out_if: result item channel (status, character, last flag)
// depends on tlrb_pkg for field widths
interface tlrb_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [tlrb_pkg::CHAR_W-1:0] char_out;
  logic                        last;

  modport source(output valid, output status, output char_out, output last, input ready);
  modport sink(input valid, input status, input char_out, input last, output ready);
endinterface

@@ hdl/tlrb_ring_alu.sv @@
// tlrb_ring_alu: shared ring position unit, increment with wrap or ring distance
// depends on tlrb_pkg for the operation type
module tlrb_ring_alu #(
  parameter int BUF_SIZE = 64,
  parameter int PW = $clog2(BUF_SIZE)
) (
  input  tlrb_pkg::alu_op_t op,
  input  logic [PW-1:0]     a,
  input  logic [PW-1:0]     b,
  output logic [PW-1:0]     y
);
  import tlrb_pkg::*;

  logic [PW:0] diff;
  logic [PW:0] diff_wrap;

  assign diff      = {1'b0, b} - {1'b0, a};
  assign diff_wrap = diff + (PW+1)'(BUF_SIZE);

  always_comb begin
    unique case (op)
      ALU_INC: begin
        y = (a == PW'(BUF_SIZE - 1)) ? '0 : a + PW'(1);
      end
      ALU_DIST: begin
        // distance from a forward to b round the ring
        y = (b >= a) ? diff[PW-1:0] : diff_wrap[PW-1:0];
      end
      default: begin
        y = a;
      end
    endcase
  end

endmodule

@@ hdl/tlrb_text_ram.sv @@
// tlrb_text_ram: ring store of line text, one write and one registered read port
// no package dependency
module tlrb_text_ram #(
  parameter int BUF_SIZE = 64,
  parameter int PW = $clog2(BUF_SIZE),
  parameter int DW = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [PW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [PW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [BUF_SIZE];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/tlrb_end_fifo.sv @@
// tlrb_end_fifo: queue of line end positions, memory with head, tail and count
// depends on tlrb_pkg for the control struct
module tlrb_end_fifo #(
  parameter int DEPTH = 16,
  parameter int DW = 6,
  parameter int EW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CW = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  tlrb_pkg::fifo_ctl_t ctl,
  input  logic [DW-1:0]       wdata,
  output logic [DW-1:0]       rdata,
  output logic                full,
  output logic                empty
);
  import tlrb_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;
  logic [EW-1:0] head_r, head_nxt;
  logic [EW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.push && !full) begin
      tail_nxt  = (tail_r == EW'(DEPTH - 1)) ? '0 : tail_r + EW'(1);
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop && !empty) begin
      head_nxt  = (head_r == EW'(DEPTH - 1)) ? '0 : head_r + EW'(1);
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !full) begin
      mem[tail_r] <= wdata;
    end
    if (ctl.pop && !empty) begin
      rdata_r <= mem[head_r];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/terminated_line_ring_buffer_unit.sv @@
// terminated_line_ring_buffer_unit: top level, sequencer, config registers, result register
// depends on tlrb_pkg, tlrb_in_if, tlrb_out_if, tlrb_ring_alu, tlrb_text_ram, tlrb_end_fifo
//
//   port    | dir | handshake        | carries
//   in_if   | in  | valid / ready    | command, rx_byte, max_len
//   out_if  | out | valid / ready    | status, char_out, last
//   cfg_*   | in  | cfg_we, no ready | register index and data
//
// a received byte is taken while idle, when ready is high, so bytes can follow back to back
// a read pops line ends (POP, LEN) until one fits, then fetches each character (RD, OUT),
// or gives a no-line result (NONE) on an empty queue; text read port and ring unit are shared
// a stalled result register holds the sequencer; no item is taken during a read
// synchronous active-low reset empties the queue and zeroes the positions
module terminated_line_ring_buffer_unit #(
  parameter int BUF_SIZE  = 64,
  parameter int END_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tlrb_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [tlrb_pkg::BYTE_W-1:0]    cfg_wdata,
  tlrb_in_if.sink                        in_if,
  tlrb_out_if.source                     out_if
);
  import tlrb_pkg::*;

  localparam int PW = $clog2(BUF_SIZE);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_POP  = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;
  localparam logic [2:0] ST_NONE = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [BYTE_W-1:0] end_symbol_r;
  logic [CHAR_W-1:0] min_print_r;
  logic [PW-1:0]     write_pos_r, write_pos_nxt;
  logic [PW-1:0]     read_pos_r, read_pos_nxt;
  logic [PW-1:0]     cur_r, cur_nxt;
  logic [LEN_W-1:0]  remain_r, remain_nxt;
  logic [LEN_W-1:0]  max_len_r, max_len_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_acc;
  logic              out_free;
  logic              is_end;
  logic              is_print;
  logic              ram_we;
  logic              ram_re;
  logic [CHAR_W-1:0] ram_rdata;
  fifo_ctl_t         fifo_ctl;
  logic [PW-1:0]     eq_rdata;
  logic              eq_full;
  logic              eq_empty;
  alu_op_t           alu_op;
  logic [PW-1:0]     alu_a;
  logic [PW-1:0]     alu_b;
  logic [PW-1:0]     alu_y;
  logic              line_fits;

  assign in_if.ready     = (state_r == ST_IDLE);
  assign out_if.valid    = out_valid_r;
  assign out_if.status   = out_status_r;
  assign out_if.char_out = out_char_r;
  assign out_if.last     = out_last_r;

  assign in_acc   = in_if.valid && in_if.ready;
  assign out_free = !out_valid_r || out_if.ready;

  // terminator wins over the printable test; other bytes with the top bit set are dropped
  assign is_end   = (in_if.rx_byte == end_symbol_r);
  assign is_print = !in_if.rx_byte[BYTE_W-1] &&
                    (in_if.rx_byte[CHAR_W-1:0] >= min_print_r);

  assign ram_we        = in_acc && !in_if.command && !is_end && is_print;
  assign ram_re        = (state_r == ST_RD);
  assign fifo_ctl.push = in_acc && !in_if.command && is_end;
  assign fifo_ctl.pop  = (state_r == ST_POP);

  assign line_fits = (alu_y != '0) && (LEN_W'(alu_y) < max_len_r);

  always_comb begin
    alu_op = ALU_INC;
    alu_a  = write_pos_r;
    alu_b  = eq_rdata;
    unique case (state_r)
      ST_LEN: begin
        alu_op = ALU_DIST;
        alu_a  = read_pos_r;
      end
      ST_RD: begin
        alu_a = cur_r;
      end
      default: begin
        alu_a = write_pos_r;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    write_pos_nxt  = write_pos_r;
    read_pos_nxt   = read_pos_r;
    cur_nxt        = cur_r;
    remain_nxt     = remain_r;
    max_len_nxt    = max_len_r;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_status_nxt = out_status_r;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_if.command) begin
          max_len_nxt = in_if.max_len;
          state_nxt   = ST_POP;
        end
        if (ram_we) begin
          write_pos_nxt = alu_y;
        end
      end
      ST_POP: begin
        state_nxt = eq_empty ? ST_NONE : ST_LEN;
      end
      ST_LEN: begin
        // the popped line is consumed whether or not it is delivered
        read_pos_nxt = eq_rdata;
        cur_nxt      = read_pos_r;
        remain_nxt   = LEN_W'(alu_y);
        state_nxt    = line_fits ? ST_RD : ST_POP;
      end
      ST_RD: begin
        cur_nxt    = alu_y;
        remain_nxt = remain_r - LEN_W'(1);
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_CHAR;
          out_char_nxt   = ram_rdata;
          out_last_nxt   = (remain_r == '0);
          state_nxt      = (remain_r == '0) ? ST_IDLE : ST_RD;
        end
      end
      ST_NONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_NO_LINE;
          out_char_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      write_pos_r  <= '0;
      read_pos_r   <= '0;
      out_valid_r  <= 1'b0;
      end_symbol_r <= END_SYMBOL_RST;
      min_print_r  <= MIN_PRINT_RST;
    end else begin
      state_r     <= state_nxt;
      write_pos_r <= write_pos_nxt;
      read_pos_r  <= read_pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_END_SYMBOL: end_symbol_r <= cfg_wdata;
          CFG_MIN_PRINT:  min_print_r  <= cfg_wdata[CHAR_W-1:0];
          default: begin
            end_symbol_r <= end_symbol_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    remain_r     <= remain_nxt;
    max_len_r    <= max_len_nxt;
    out_status_r <= out_status_nxt;
    out_char_r   <= out_char_nxt;
    out_last_r   <= out_last_nxt;
  end

  tlrb_ring_alu #(
    .BUF_SIZE(BUF_SIZE)
  ) u_alu (
    .op(alu_op),
    .a (alu_a),
    .b (alu_b),
    .y (alu_y)
  );

  tlrb_text_ram #(
    .BUF_SIZE(BUF_SIZE),
    .DW      (CHAR_W)
  ) u_text (
    .clk  (clk),
    .we   (ram_we),
    .waddr(write_pos_r),
    .wdata(in_if.rx_byte[CHAR_W-1:0]),
    .re   (ram_re),
    .raddr(cur_r),
    .rdata(ram_rdata)
  );

  tlrb_end_fifo #(
    .DEPTH(END_DEPTH),
    .DW   (PW)
  ) u_ends (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (fifo_ctl),
    .wdata(write_pos_r),
    .rdata(eq_rdata),
    .full (eq_full),
    .empty(eq_empty)
  );

  // a full queue drops the terminator; the write position is untouched then
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (fifo_ctl.push && eq_full) |=> $stable(write_pos_r))
    else $error("terminator on full queue changed the write position");

  a_no_line_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STAT_NO_LINE)) |-> (out_last_r && (out_char_r == '0)))
    else $error("no-line result without last flag or with a character");

  a_remain_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (remain_r != '0))
    else $error("character fetch with no characters left");

  a_read_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.command) |=> !in_if.ready)
    else $error("input taken while a read is in progress");

endmodule
